// ===== src/ltp_pkg.sv =====
// Package for the last-press tone priority block: field widths, opcodes,
// action codes, register indexes, reset values and the shared struct types.
// Used by every module in src; depends on nothing.
`default_nettype none

package ltp_pkg;

  // Field widths of one input item and one result item.
  localparam int OP_W     = 3;
  localparam int BTN_W    = 3;
  localparam int HELD_W   = 5;
  localparam int TIME_W   = 32;
  localparam int ACT_W    = 2;
  localparam int PITCH_W  = 3;
  localparam int DUR_W    = 16;
  localparam int CNT_W    = 4;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 24;

  // Configuration port.
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;
  localparam logic [CFG_AW-1:0] REG_BEEP_MS    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAP_MS     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PAUSE_MS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BEEP_COUNT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CLICK_MS   = 3'd4;

  localparam logic [DUR_W-1:0] BEEP_MS_RST    = 16'd100;
  localparam logic [DUR_W-1:0] GAP_MS_RST     = 16'd100;
  localparam logic [DUR_W-1:0] PAUSE_MS_RST   = 16'd500;
  localparam logic [CNT_W-1:0] BEEP_COUNT_RST = 4'd3;
  localparam logic [DUR_W-1:0] CLICK_MS_RST   = 16'd100;
  localparam logic [CNT_W-1:0] BEEP_COUNT_MAX = 4'd8;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PRESS = 3'd1;
  localparam logic [OP_W-1:0] OP_CLICK = 3'd2;
  localparam logic [OP_W-1:0] OP_START = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  // Actions and special pitches.
  localparam logic [ACT_W-1:0] ACT_SILENCE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TONE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMED   = 2'd2;
  localparam logic [BTN_W-1:0] NO_BUTTON   = 3'd5;
  localparam logic [PITCH_W-1:0] ALARM_PITCH = 3'd5;

  // Alarm arithmetic: (index - 1) * (beep + gap) fits in PROD_W bits.
  localparam int PROD_W = 21;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [PITCH_W-1:0] pitch;
    logic [DUR_W-1:0]   duration;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic rel_step;
    logic top_pick;
    logic alm_mul;
    logic alm_cmp;
    logic emit0;
    logic emit1;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic alarm_on;
    logic sweep_last;
    logic res0_v;
    logic res1_v;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/last_press_tone_priority.sv =====
// Top level of the last-press tone priority speaker command generator.
// Instantiates ltp_ctrl, ltp_dp and ltp_out; depends on ltp_pkg.
//
// The block turns button and alarm events into speaker commands: the most
// recently pressed button that is still held sounds as a continuous tone,
// releases seen on a tick hand the tone to the next most recent held button
// or silence it, clicks give timed tones, and while the alarm runs presses
// and clicks are ignored and ticks step a beep, gap and pause cycle. An item
// takes one transaction on the in_ channel and gives zero, one or two
// result transactions on the out_ channel, the last of them marked by
// out_tlast. Sequence: a press, click, alarm start or alarm stop passes
// through the execute and emit states before the next item can be
// accepted; a tick passes through the release sweep, which visits one
// button per cycle, the top pick and, with the alarm on, the alarm
// multiply and compare states, then the emit states. A result waits in an
// output register, so an emission stalls only while that register holds a
// result that downstream has not yet taken. Configuration writes take
// effect at once and are meant to be issued while the block is idle.
`default_nettype none

module last_press_tone_priority #(
  parameter int NUM_BUTTONS = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [ltp_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [ltp_pkg::CFG_DW-1:0]    cfg_wdata,
  // Input item channel.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // opcode [2:0], button [5:3], held_mask [10:6], now_ms [42:11], zero pad
  input  wire logic [ltp_pkg::IN_W-1:0]      in_tdata,
  // Result channel.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // action [1:0], pitch [4:2], duration_ms [20:5], zero pad
  output logic [ltp_pkg::OUT_W-1:0]          out_tdata,
  output logic                               out_tlast
);

  ltp_pkg::cmd_t  cmd;
  ltp_pkg::stat_t stat;
  ltp_pkg::res_t  emit_res;
  logic           emit_last;
  logic           out_free;
  logic           idle;

  logic [ltp_pkg::OP_W-1:0]   in_op;
  logic [ltp_pkg::BTN_W-1:0]  in_btn;
  logic [ltp_pkg::HELD_W-1:0] in_held;
  logic [ltp_pkg::TIME_W-1:0] in_now;

  assign in_op   = in_tdata[2:0];
  assign in_btn  = in_tdata[5:3];
  assign in_held = in_tdata[10:6];
  assign in_now  = in_tdata[42:11];

  // The controller takes a new item only from its idle state.
  assign in_tready = idle;

  ltp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  ltp_dp #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_op),
    .in_btn    (in_btn),
    .in_held   (in_held),
    .in_now    (in_now),
    .cmd       (cmd),
    .stat      (stat),
    .emit_res  (emit_res),
    .emit_last (emit_last)
  );

  // Results are pushed only when the output register is free or draining.
  ltp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd.emit0 || cmd.emit1),
    .res        (emit_res),
    .last       (emit_last),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // A result is never pushed over one that downstream has not taken.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit0 || cmd.emit1) |-> out_free)
    else $error("result pushed into a full output register");

  // The two result slots are never emitted in the same cycle.
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit0 && cmd.emit1))
    else $error("both result slots emitted at once");

  // In the cycle after an item is accepted the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");
`endif

endmodule

`default_nettype wire

// ===== src/ltp_ctrl.sv =====
// Controller state machine of the last-press tone priority block.
// Sequences load, execute, release sweep, top pick, alarm step and result emission.
// Depends on ltp_pkg.
`default_nettype none

module ltp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_free,
  input  wire ltp_pkg::stat_t stat,
  output logic               idle,
  output ltp_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_REL   = 3'd2;
  localparam logic [2:0] S_TOP   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_EMIT0 = 3'd6;
  localparam logic [2:0] S_EMIT1 = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          state_nxt = S_REL;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_EMIT0;
        end
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        cmd.top_pick = 1'b1;
        state_nxt    = stat.alarm_on ? S_MUL : S_EMIT0;
      end
      S_MUL: begin
        cmd.alm_mul = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.alm_cmp = 1'b1;
        state_nxt   = S_EMIT0;
      end
      S_EMIT0: begin
        if (!stat.res0_v) begin
          state_nxt = stat.res1_v ? S_EMIT1 : S_IDLE;
        end else if (out_free) begin
          cmd.emit0 = 1'b1;
          state_nxt = stat.res1_v ? S_EMIT1 : S_IDLE;
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          cmd.emit1 = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ltp_dp.sv =====
// Datapath of the last-press tone priority block: configuration registers,
// press ranks, alarm timing arithmetic and the two pending result slots.
// Depends on ltp_pkg; driven by commands from ltp_ctrl.
`default_nettype none

module ltp_dp #(
  parameter int NUM_BUTTONS = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ltp_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [ltp_pkg::CFG_DW-1:0]    cfg_wdata,
  input  wire logic [ltp_pkg::OP_W-1:0]      in_op,
  input  wire logic [ltp_pkg::BTN_W-1:0]     in_btn,
  input  wire logic [ltp_pkg::HELD_W-1:0]    in_held,
  input  wire logic [ltp_pkg::TIME_W-1:0]    in_now,
  input  wire ltp_pkg::cmd_t                 cmd,
  output ltp_pkg::stat_t                     stat,
  output ltp_pkg::res_t                      emit_res,
  output logic                               emit_last
);

  localparam int RW = $clog2(NUM_BUTTONS + 1);
  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int HX = 8;

  // Configuration registers.
  logic [ltp_pkg::DUR_W-1:0] beep_ms_r, gap_ms_r, pause_ms_r, click_ms_r;
  logic [ltp_pkg::CNT_W-1:0] beep_cnt_r;

  // Captured item.
  logic [ltp_pkg::OP_W-1:0]   op_r;
  logic [ltp_pkg::BTN_W-1:0]  btn_r;
  logic [ltp_pkg::HELD_W-1:0] held_r;
  logic [ltp_pkg::TIME_W-1:0] now_r;

  // Block state.
  logic                        alarm_r, alarm_nxt;
  logic [ltp_pkg::TIME_W-1:0]  cstart_r, cstart_nxt;
  logic [ltp_pkg::CNT_W-1:0]   bidx_r, bidx_nxt;
  logic [RW-1:0]               rank_r [NUM_BUTTONS];
  logic [RW-1:0]               rank_nxt [NUM_BUTTONS];
  logic [RW-1:0]               count_r, count_nxt;
  logic [ltp_pkg::BTN_W-1:0]   top_r, top_nxt;
  logic                        top_lost_r, top_lost_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  ltp_pkg::res_t               res0_r, res0_nxt, res1_r, res1_nxt;
  logic                        res0_v_r, res0_v_nxt, res1_v_r, res1_v_nxt;

  // Alarm step intermediates.
  logic [ltp_pkg::PROD_W-1:0] prod_r;
  logic [ltp_pkg::TIME_W-1:0] el_r;
  logic [ltp_pkg::DUR_W:0]    add_r;
  logic                       kgt_r;
  logic [ltp_pkg::CNT_W-1:0]  keff_r;

  // Combinational helpers.
  logic [IW-1:0]               sel_idx;
  logic [RW-1:0]               ref_rank;
  logic                        btn_ok;
  logic [HX-1:0]               held_ext;
  logic                        held_bit;
  logic                        match_found;
  logic [ltp_pkg::BTN_W-1:0]   match_idx;
  logic [ltp_pkg::CNT_W-1:0]   cnt_eff, keff, mop;
  logic [ltp_pkg::DUR_W:0]     bg_sum;
  logic                        kgt;
  logic [ltp_pkg::TIME_W-1:0]  lo32, bound32;

  assign sel_idx  = cmd.exec ? IW'(btn_r) : idx_r;
  assign ref_rank = rank_r[sel_idx];
  assign btn_ok   = ({1'b0, btn_r} < (ltp_pkg::BTN_W + 1)'(NUM_BUTTONS));
  assign held_ext = {{(HX - ltp_pkg::HELD_W){1'b0}}, held_r};
  assign held_bit = held_ext[ltp_pkg::BTN_W'(idx_r)];

  // Ranks of held buttons are distinct and run 1..count, so the new top is
  // the button whose rank equals the count.
  always_comb begin
    match_found = 1'b0;
    match_idx   = ltp_pkg::NO_BUTTON;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!match_found && count_r != '0 && rank_r[i] == count_r) begin
        match_found = 1'b1;
        match_idx   = ltp_pkg::BTN_W'(i);
      end
    end
  end

  // Alarm operands: a count of zero acts as one, above eight as eight.
  always_comb begin
    if (beep_cnt_r == '0) begin
      cnt_eff = ltp_pkg::CNT_W'(1);
    end else if (beep_cnt_r > ltp_pkg::BEEP_COUNT_MAX) begin
      cnt_eff = ltp_pkg::BEEP_COUNT_MAX;
    end else begin
      cnt_eff = beep_cnt_r;
    end
    keff   = (bidx_r == '0) ? ltp_pkg::CNT_W'(1) : bidx_r;
    kgt    = (bidx_r > cnt_eff);
    mop    = kgt ? (cnt_eff - ltp_pkg::CNT_W'(1)) : (keff - ltp_pkg::CNT_W'(1));
    bg_sum = {1'b0, beep_ms_r} + {1'b0, gap_ms_r};
  end

  assign lo32    = ltp_pkg::TIME_W'(prod_r);
  assign bound32 = ltp_pkg::TIME_W'(prod_r) + ltp_pkg::TIME_W'(add_r);

  always_comb begin
    alarm_nxt    = alarm_r;
    cstart_nxt   = cstart_r;
    bidx_nxt     = bidx_r;
    rank_nxt     = rank_r;
    count_nxt    = count_r;
    top_nxt      = top_r;
    top_lost_nxt = top_lost_r;
    idx_nxt      = idx_r;
    res0_nxt     = res0_r;
    res1_nxt     = res1_r;
    res0_v_nxt   = res0_v_r;
    res1_v_nxt   = res1_v_r;

    if (cmd.load) begin
      res0_v_nxt   = 1'b0;
      res1_v_nxt   = 1'b0;
      top_lost_nxt = 1'b0;
      idx_nxt      = '0;
    end

    if (cmd.exec) begin
      case (op_r)
        ltp_pkg::OP_PRESS: begin
          if (!alarm_r && btn_ok) begin
            if (ref_rank != '0) begin
              // Repeated press: close up the ranks above the old one.
              for (int j = 0; j < NUM_BUTTONS; j++) begin
                if (rank_r[j] > ref_rank) begin
                  rank_nxt[j] = rank_r[j] - RW'(1);
                end
              end
              rank_nxt[sel_idx] = count_r;
            end else begin
              count_nxt         = count_r + RW'(1);
              rank_nxt[sel_idx] = count_r + RW'(1);
            end
            top_nxt    = btn_r;
            res0_nxt   = '{ltp_pkg::ACT_TONE, btn_r, '0};
            res0_v_nxt = 1'b1;
          end
        end
        ltp_pkg::OP_CLICK: begin
          if (!alarm_r && btn_ok) begin
            res0_nxt   = '{ltp_pkg::ACT_TIMED, btn_r, click_ms_r};
            res0_v_nxt = 1'b1;
          end
        end
        ltp_pkg::OP_START: begin
          cstart_nxt = now_r;
          bidx_nxt   = ltp_pkg::CNT_W'(1);
          alarm_nxt  = 1'b1;
        end
        ltp_pkg::OP_STOP: begin
          alarm_nxt  = 1'b0;
          res0_nxt   = '{ltp_pkg::ACT_SILENCE, '0, '0};
          res0_v_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cmd.rel_step) begin
      if (ref_rank != '0 && !held_bit) begin
        if (count_r != '0) begin
          count_nxt = count_r - RW'(1);
        end
        for (int j = 0; j < NUM_BUTTONS; j++) begin
          if (rank_r[j] > ref_rank) begin
            rank_nxt[j] = rank_r[j] - RW'(1);
          end
        end
        rank_nxt[idx_r] = '0;
        if (ltp_pkg::BTN_W'(idx_r) == top_r) begin
          top_lost_nxt = 1'b1;
        end
      end
      idx_nxt = IW'(idx_r + IW'(1));
    end

    if (cmd.top_pick && top_lost_r) begin
      top_nxt    = match_idx;
      res0_v_nxt = 1'b1;
      if (match_found) begin
        res0_nxt = '{ltp_pkg::ACT_TONE, match_idx, '0};
      end else begin
        res0_nxt = '{ltp_pkg::ACT_SILENCE, '0, '0};
      end
    end

    if (cmd.alm_cmp) begin
      if (kgt_r) begin
        // Pause after the last beep: restart the cycle once it has run out.
        if (el_r > bound32) begin
          cstart_nxt = now_r;
          bidx_nxt   = ltp_pkg::CNT_W'(1);
        end
      end else begin
        if (el_r > lo32 && el_r <= bound32) begin
          res1_nxt   = '{ltp_pkg::ACT_TONE, ltp_pkg::ALARM_PITCH, '0};
          res1_v_nxt = 1'b1;
        end
        if (el_r > bound32) begin
          bidx_nxt   = keff_r + ltp_pkg::CNT_W'(1);
          res1_nxt   = '{ltp_pkg::ACT_SILENCE, '0, '0};
          res1_v_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_ms_r  <= ltp_pkg::BEEP_MS_RST;
      gap_ms_r   <= ltp_pkg::GAP_MS_RST;
      pause_ms_r <= ltp_pkg::PAUSE_MS_RST;
      beep_cnt_r <= ltp_pkg::BEEP_COUNT_RST;
      click_ms_r <= ltp_pkg::CLICK_MS_RST;
      alarm_r    <= 1'b0;
      cstart_r   <= '0;
      bidx_r     <= ltp_pkg::CNT_W'(1);
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        rank_r[j] <= '0;
      end
      count_r    <= '0;
      top_r      <= ltp_pkg::NO_BUTTON;
      top_lost_r <= 1'b0;
      idx_r      <= '0;
      res0_v_r   <= 1'b0;
      res1_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ltp_pkg::REG_BEEP_MS:    beep_ms_r  <= cfg_wdata;
          ltp_pkg::REG_GAP_MS:     gap_ms_r   <= cfg_wdata;
          ltp_pkg::REG_PAUSE_MS:   pause_ms_r <= cfg_wdata;
          ltp_pkg::REG_BEEP_COUNT: beep_cnt_r <= cfg_wdata[ltp_pkg::CNT_W-1:0];
          ltp_pkg::REG_CLICK_MS:   click_ms_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      alarm_r    <= alarm_nxt;
      cstart_r   <= cstart_nxt;
      bidx_r     <= bidx_nxt;
      rank_r     <= rank_nxt;
      count_r    <= count_nxt;
      top_r      <= top_nxt;
      top_lost_r <= top_lost_nxt;
      idx_r      <= idx_nxt;
      res0_v_r   <= res0_v_nxt;
      res1_v_r   <= res1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    if (cmd.load) begin
      op_r   <= in_op;
      btn_r  <= in_btn;
      held_r <= in_held;
      now_r  <= in_now;
    end
    if (cmd.alm_mul) begin
      prod_r <= ltp_pkg::PROD_W'(mop) * ltp_pkg::PROD_W'(bg_sum);
      el_r   <= now_r - cstart_r;
      add_r  <= kgt ? ({1'b0, beep_ms_r} + {1'b0, pause_ms_r}) : {1'b0, beep_ms_r};
      kgt_r  <= kgt;
      keff_r <= keff;
    end
  end

  assign stat.is_tick    = (op_r == ltp_pkg::OP_TICK);
  assign stat.alarm_on   = alarm_r;
  assign stat.sweep_last = (idx_r == IW'(NUM_BUTTONS - 1));
  assign stat.res0_v     = res0_v_r;
  assign stat.res1_v     = res1_v_r;

  assign emit_res  = cmd.emit1 ? res1_r : res0_r;
  assign emit_last = cmd.emit1 ? 1'b1 : !res1_v_r;

endmodule

`default_nettype wire

// ===== src/ltp_out.sv =====
// Output register of the last-press tone priority block: one result
// transaction held for the downstream side while the block moves on.
// Depends on ltp_pkg.
`default_nettype none

module ltp_out (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire ltp_pkg::res_t              res,
  input  wire logic                       last,
  output logic                            out_free,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [ltp_pkg::OUT_W-1:0]       out_tdata,
  output logic                            out_tlast
);

  logic          valid_r, valid_nxt;
  ltp_pkg::res_t res_r;
  logic          last_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r  <= res;
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.duration, res_r.pitch, res_r.action};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== tb/ltp_tone_checker.sv =====
// Scoreboard for the last-press tone priority block: watches the configuration
// port and both stream channels, predicts every tone command and compares it.
// Depends on ltp_pkg for field widths, opcodes, actions and register indexes.
module ltp_tone_checker
  import ltp_pkg::*;
#(
  parameter int NUM_BUTTONS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [OUT_W-1:0]  out_tdata,
  input  wire logic              out_tlast,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [PITCH_W-1:0] pitch;
    logic [DUR_W-1:0]   dur;
    logic               last;
  } tone_cmd_t;

  tone_cmd_t tone_q[$];
  tone_cmd_t step_buf[$];
  int        mismatches = 0;

  // Shadow registers.
  logic [DUR_W-1:0] beep_len, gap_len, pause_len, click_len;
  logic [CNT_W-1:0] beeps_per_cycle;

  // Shadow state.
  logic             alarm_active;
  logic [TIME_W-1:0] cycle_t0;
  logic [CNT_W-1:0] beep_no;
  logic [2:0]       rank [NUM_BUTTONS];
  logic [2:0]       held_total;
  logic [BTN_W-1:0] sounding;

  assign fail_count = mismatches;

  function automatic void emit(input logic [ACT_W-1:0] a, input logic [PITCH_W-1:0] p,
                               input logic [DUR_W-1:0] d);
    tone_cmd_t c;
    c.action = a;
    c.pitch  = p;
    c.dur    = d;
    c.last   = 1'b0;
    step_buf.push_back(c);
  endfunction

  // Released buttons give up their rank and the ranks above close up; if the
  // sounding button went away, the highest remaining rank sounds instead.
  task automatic release_buttons(input logic [HELD_W-1:0] held);
    int i, j;
    logic [2:0] best;
    for (i = 0; i < NUM_BUTTONS; i++) begin
      if (rank[i] != 0 && !held[i]) begin
        if (held_total != 0) held_total--;
        for (j = 0; j < NUM_BUTTONS; j++)
          if (rank[j] > rank[i]) rank[j]--;
        rank[i] = '0;
      end
    end
    if (sounding < NUM_BUTTONS && rank[sounding] == 0) begin
      best = '0;
      sounding = NO_BUTTON;
      for (i = 0; i < NUM_BUTTONS; i++) begin
        if (rank[i] > best) begin
          best = rank[i];
          sounding = BTN_W'(i);
        end
      end
      if (sounding == NO_BUTTON) emit(ACT_SILENCE, '0, '0);
      else emit(ACT_TONE, sounding, '0);
    end
  endtask

  task automatic alarm_step(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since;
    longint unsigned el, n, b, g, k, lo, hi;
    since = now - cycle_t0;
    el = since;
    if (beeps_per_cycle == '0) n = 1;
    else if (beeps_per_cycle > BEEP_COUNT_MAX) n = BEEP_COUNT_MAX;
    else n = beeps_per_cycle;
    b = beep_len;
    g = gap_len;
    k = beep_no;
    if (k > n) begin
      // Waiting out the pause; the cycle restarts once it has passed.
      if (el > n * b + (n - 1) * g + pause_len) begin
        cycle_t0 = now;
        beep_no  = 1;
      end
    end else begin
      if (k == 0) k = 1;
      lo = (k - 1) * b + (k - 1) * g;
      hi = k * b + (k - 1) * g;
      if (el > lo && el <= hi) emit(ACT_TONE, ALARM_PITCH, '0);
      if (el > hi) begin
        beep_no = CNT_W'(k + 1);
        emit(ACT_SILENCE, '0, '0);
      end
    end
  endtask

  task automatic predict_tones(input logic [IN_W-1:0] d);
    logic [OP_W-1:0]   op;
    logic [BTN_W-1:0]  btn;
    logic [HELD_W-1:0] held;
    logic [TIME_W-1:0] now;
    logic [2:0]        old;
    int                j;
    op   = d[OP_W-1:0];
    btn  = d[OP_W +: BTN_W];
    held = d[OP_W+BTN_W +: HELD_W];
    now  = d[OP_W+BTN_W+HELD_W +: TIME_W];
    step_buf.delete();
    case (op)
      OP_TICK: begin
        release_buttons(held);
        if (alarm_active) alarm_step(now);
      end
      OP_PRESS: begin
        if (!alarm_active && btn < NUM_BUTTONS) begin
          old = rank[btn];
          if (old != 0) begin
            // Repeated press: move to the top without counting a new press.
            for (j = 0; j < NUM_BUTTONS; j++)
              if (rank[j] > old) rank[j]--;
          end else begin
            held_total++;
          end
          rank[btn] = held_total;
          sounding  = btn;
          emit(ACT_TONE, btn, '0);
        end
      end
      OP_CLICK: begin
        if (!alarm_active && btn < NUM_BUTTONS) emit(ACT_TIMED, btn, click_len);
      end
      OP_START: begin
        cycle_t0     = now;
        beep_no      = 1;
        alarm_active = 1'b1;
      end
      OP_STOP: begin
        alarm_active = 1'b0;
        emit(ACT_SILENCE, '0, '0);
      end
      default: ;
    endcase
    if (step_buf.size() > 0) step_buf[step_buf.size()-1].last = 1'b1;
    foreach (step_buf[i]) tone_q.push_back(step_buf[i]);
  endtask

  always @(posedge clk) begin
    tone_cmd_t want;
    if (!rst_n) begin
      beep_len        = BEEP_MS_RST;
      gap_len         = GAP_MS_RST;
      pause_len       = PAUSE_MS_RST;
      beeps_per_cycle = BEEP_COUNT_RST;
      click_len       = CLICK_MS_RST;
      alarm_active    = 1'b0;
      cycle_t0        = '0;
      beep_no         = 1;
      foreach (rank[i]) rank[i] = '0;
      held_total      = '0;
      sounding        = NO_BUTTON;
      tone_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BEEP_MS:    beep_len = cfg_wdata;
          REG_GAP_MS:     gap_len = cfg_wdata;
          REG_PAUSE_MS:   pause_len = cfg_wdata;
          REG_BEEP_COUNT: beeps_per_cycle = cfg_wdata[CNT_W-1:0];
          REG_CLICK_MS:   click_len = cfg_wdata;
          default: ;
        endcase
      end
      // A result always belongs to an earlier input, so check it first.
      if (out_tvalid && out_tready) begin
        if (tone_q.size() == 0) begin
          $display("%0t: unexpected tone command: action %0d pitch %0d dur %0d last %0b",
                   $time, out_tdata[1:0], out_tdata[4:2], out_tdata[20:5], out_tlast);
          mismatches++;
        end else begin
          want = tone_q.pop_front();
          if (out_tdata[1:0] !== want.action || out_tdata[4:2] !== want.pitch ||
              out_tdata[20:5] !== want.dur || out_tlast !== want.last) begin
            $display("%0t: tone mismatch: expected action %0d pitch %0d dur %0d last %0b, got action %0d pitch %0d dur %0d last %0b",
                     $time, want.action, want.pitch, want.dur, want.last,
                     out_tdata[1:0], out_tdata[4:2], out_tdata[20:5], out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_tones(in_tdata);
    end
    pending <= tone_q.size();
  end

endmodule

// ===== tb/tb_last_press_tone_priority.sv =====
// Top of the testbench for last_press_tone_priority: clock, reset, stimulus,
// receiver back-pressure and the final verdict. Depends on ltp_pkg, the block
// under test and ltp_tone_checker, which does all prediction and comparison.
module tb_last_press_tone_priority;
  import ltp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUTTONS  = 5;
  localparam int CYCLE_LIMIT  = 500000;
  // Margin for a tick with the alarm running that produces nothing to finish
  // before registers are touched.
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int PHASES       = 8;

  // Opcodes and a register index that the block has no use for.
  localparam logic [OP_W-1:0]   OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE7 = 3'd7;
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd5;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;

  int fail_count;
  int pending;

  // Receiver control, written by the stimulus process and read by the
  // receiver process.
  int unsigned stall_pct = 0;
  logic        hold_token = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // Stimulus-side view of the world: which buttons the player is holding,
  // whether the alarm should be running, and the millisecond clock.
  int unsigned       send_idle_pct = 0;
  logic [HELD_W-1:0] phys_held = '0;
  logic              alarm_want = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned       step_max = 100;

  int unsigned cycle_no = 0;

  last_press_tone_priority #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ltp_tone_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver. A change of hold_token starts a long hold-off that this process
  // counts down by itself; otherwise it stalls at the rate the phase asks.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("last_press_tone_priority verification failed");
      $finish;
    end
  end

  // Offers one item, idling first at the phase's rate, and returns right after
  // the edge at which the transaction happened. The valid flag is left high so
  // that back-to-back items do not drop it.
  task automatic drive_item(input logic [OP_W-1:0] op, input logic [BTN_W-1:0] btn,
                            input logic [HELD_W-1:0] held, input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-OP_W-BTN_W-HELD_W-TIME_W){1'b0}}, now, held, btn, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted tone command has come
  // out, then lets the block finish any item that produces nothing.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Puts one register write on the port and leaves the write enable high.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes the whole register set. The upper bits of the beep count word are
  // random since only the low nibble is kept.
  task automatic program_alarm(input logic [DUR_W-1:0] beep, input logic [DUR_W-1:0] gap,
                               input logic [DUR_W-1:0] pause, input logic [CNT_W-1:0] count,
                               input logic [DUR_W-1:0] click);
    write_reg(REG_BEEP_MS, beep);
    write_reg(REG_GAP_MS, gap);
    write_reg(REG_PAUSE_MS, pause);
    write_reg(REG_BEEP_COUNT, {(CFG_DW-CNT_W)'($urandom()), count});
    write_reg(REG_CLICK_MS, click);
    cfg_we <= 1'b0;
    // Ticks advance time by up to about half a beep plus gap, so the alarm
    // cycle is walked through in several steps.
    step_max = (int'(beep) + int'(gap)) / 2 + 2;
  endtask

  // Directed opening under the reset register values: a click, presses that
  // build a rank order, a repeated press, presses and clicks for no button,
  // releases that hand the tone down and then silence it, presses and clicks
  // ignored under the alarm, a full alarm cycle across the wrap of the time
  // counter including a tick that both hands over the tone and ends a beep,
  // the restart after the pause, unused opcodes and the alarm stop.
  task automatic run_directed();
    logic [TIME_W-1:0] base;
    base = 32'hFFFF_FF80;
    drive_item(OP_CLICK, 3'd0, 5'b00000, base);
    drive_item(OP_PRESS, 3'd4, 5'b00000, base);
    drive_item(OP_PRESS, 3'd0, 5'b00000, base);
    drive_item(OP_PRESS, 3'd2, 5'b00000, base);
    drive_item(OP_PRESS, 3'd0, 5'b00000, base);
    drive_item(OP_PRESS, NO_BUTTON, 5'b00000, base);
    drive_item(OP_CLICK, 3'd7, 5'b11111, base);
    drive_item(OP_TICK, 3'd0, 5'b10101, base);
    drive_item(OP_TICK, 3'd0, 5'b10100, base);
    drive_item(OP_TICK, 3'd0, 5'b00000, base);
    drive_item(OP_PRESS, 3'd1, 5'b00000, base);
    drive_item(OP_PRESS, 3'd3, 5'b00000, base);
    drive_item(OP_START, 3'd0, 5'b00000, base);
    drive_item(OP_PRESS, 3'd2, 5'b00000, base);
    drive_item(OP_CLICK, 3'd2, 5'b00000, base);
    drive_item(OP_TICK, 3'd0, 5'b01010, base + 32'd50);
    drive_item(OP_TICK, 3'd0, 5'b00010, base + 32'd150);
    drive_item(OP_TICK, 3'd0, 5'b00010, base + 32'd250);
    drive_item(OP_TICK, 3'd0, 5'b00010, base + 32'd1000);
    drive_item(OP_TICK, 3'd0, 5'b00010, base + 32'd1200);
    drive_item(OP_TICK, 3'd0, 5'b00010, base + 32'd1201);
    drive_item(OP_SPARE5, 3'd6, 5'b11111, 32'hFFFF_FFFF);
    drive_item(OP_SPARE7, 3'd5, 5'b01010, 32'h0000_0000);
    drive_item(OP_STOP, 3'd0, 5'b00000, base + 32'd1300);
    drive_item(OP_TICK, 3'd7, 5'b11111, 32'hFFFF_FFFF);
    drive_item(OP_TICK, 3'd0, 5'b00000, 32'h0000_0000);
    phys_held  = '0;
    alarm_want = 1'b0;
  endtask

  // One random item. Most items follow what a player does: presses add to the
  // held set, ticks release some held buttons and advance the clock, the
  // alarm is started and stopped now and then. The rest is noise with every
  // field random.
  task automatic random_event(output bit counted);
    int unsigned       pick;
    int                i;
    logic [OP_W-1:0]   op;
    logic [BTN_W-1:0]  btn;
    logic [HELD_W-1:0] mask;
    logic [TIME_W-1:0] stamp;
    pick    = $urandom_range(99);
    btn     = BTN_W'($urandom_range(NUM_BUTTONS - 1));
    counted = 1'b1;
    if (pick < 15) begin
      op      = OP_W'($urandom());
      btn     = BTN_W'($urandom());
      mask    = HELD_W'($urandom());
      stamp   = $urandom();
      case (op)
        OP_TICK: begin
          phys_held &= mask;
          clock_ms = stamp;
        end
        OP_PRESS: if (!alarm_want && btn < NUM_BUTTONS) phys_held[btn] = 1'b1;
        OP_START: begin
          alarm_want = 1'b1;
          clock_ms = stamp;
        end
        OP_STOP: alarm_want = 1'b0;
        default: ;
      endcase
      drive_item(op, btn, mask, stamp);
    end else if (pick < 22 && (!alarm_want || $urandom_range(2) == 0)) begin
      op = alarm_want ? OP_STOP : OP_START;
      alarm_want = !alarm_want;
      drive_item(op, BTN_W'($urandom()), HELD_W'($urandom()), clock_ms);
    end else if (pick < 42) begin
      if (!alarm_want) phys_held[btn] = 1'b1;
      drive_item(OP_PRESS, btn, HELD_W'($urandom()), $urandom());
    end else if (pick < 52) begin
      drive_item(OP_CLICK, btn, HELD_W'($urandom()), $urandom());
    end else begin
      for (i = 0; i < NUM_BUTTONS; i++)
        if (phys_held[i] && $urandom_range(3) == 0) phys_held[i] = 1'b0;
      // Now and then the clock jumps anywhere, wrap-around included.
      if ($urandom_range(24) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(step_max);
      drive_item(OP_TICK, BTN_W'($urandom()), phys_held, clock_ms);
    end
  endtask

  task automatic run_random(input int quota);
    int done;
    bit counted;
    done = 0;
    while (done < quota) begin
      random_event(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Each phase changes registers only once everything before it has come
    // out, then runs random traffic under its own back-pressure pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      clock_ms = $urandom();
      case (ph)
        0: begin
          program_alarm(16'd5, 16'd3, 16'd10, 4'd2, 16'd0);
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          program_alarm(16'd1, 16'd0, 16'd0, 4'd1, 16'hFFFF);
          send_idle_pct = 80;
          stall_pct <= 0;
        end
        2: begin
          program_alarm(16'hFFFF, 16'hFFFF, 16'hFFFF, BEEP_COUNT_MAX, 16'd1);
          send_idle_pct = 0;
          stall_pct <= 80;
        end
        3: begin
          // Zero beeps per cycle behaves like one.
          program_alarm(16'd7, 16'd2, 16'd4, 4'd0, 16'd37);
          send_idle_pct = 31;
          stall_pct <= 31;
        end
        4: begin
          // More than eight beeps behaves like eight. The receiver also holds
          // off for a long stretch so the block backs up into its input.
          program_alarm(16'd3, 16'd1, 16'd5, 4'hF, 16'd12);
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_token <= !hold_token;
        end
        5: begin
          program_alarm(DUR_W'($urandom_range(1, 40)), DUR_W'($urandom_range(40)),
                        DUR_W'($urandom_range(200)), CNT_W'($urandom_range(15)),
                        DUR_W'($urandom()));
          send_idle_pct = 31;
          stall_pct <= 31;
        end
        6: begin
          // A write to an index with no register must change nothing.
          write_reg(REG_SPARE, CFG_DW'($urandom()));
          program_alarm(BEEP_MS_RST, GAP_MS_RST, PAUSE_MS_RST, BEEP_COUNT_RST,
                        CLICK_MS_RST);
          send_idle_pct = 80;
          stall_pct <= 0;
        end
        default: begin
          program_alarm(DUR_W'($urandom_range(1, 300)), DUR_W'($urandom_range(300)),
                        DUR_W'($urandom_range(900)), CNT_W'($urandom_range(1, 8)),
                        DUR_W'($urandom()));
          send_idle_pct = 0;
          stall_pct <= 80;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("last_press_tone_priority verification clean");
    end else begin
      $display("last_press_tone_priority verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ltp_pkg.sv
src/ltp_ctrl.sv
src/ltp_dp.sv
src/ltp_out.sv
src/last_press_tone_priority.sv
tb/ltp_tone_checker.sv
tb/tb_last_press_tone_priority.sv
